// File: hw/rtl/strassen_matrix_multiply_defines.svh
// Assertion macros used by the checker file of the matrix multiplier.
`ifndef STRASSEN_MATRIX_MULTIPLY_DEFINES_SVH
`define STRASSEN_MATRIX_MULTIPLY_DEFINES_SVH

// Concurrent assertion, sampled on the rising clock, off while reset is low.
`define SMM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication into the next cycle.
`define SMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/smm_pkg.sv
// Shared types and constants of the matrix multiplier.
package smm_pkg;

	localparam int Size = 4;
	localparam int ElemW = 16;
	localparam int CWidth = 36;
	localparam int OutIdxW = 3;
	localparam int Cells = Size * Size;
	localparam int IdxW = $clog2(Size);
	localparam int CntW = $clog2(Cells);
	localparam int DrainCycles = Size + 2;
	localparam int DrnW = $clog2(DrainCycles + 1);

	typedef struct packed {
		logic signed [15:0] a_element;
		logic signed [15:0] b_element;
	} in_item_t;

	typedef struct packed {
		logic signed [CWidth-1:0] c_element;
		logic [OutIdxW-1:0] row_index;
		logic [OutIdxW-1:0] col_index;
		logic last_flag;
	} out_item_t;

	// one A element travelling along the cell chain
	typedef struct packed {
		logic valid;
		logic first;
		logic signed [ElemW-1:0] a;
		logic [IdxW-1:0] t;
	} feed_t;

	// B element write into one cell's column store
	typedef struct packed {
		logic en;
		logic [IdxW-1:0] row;
		logic signed [ElemW-1:0] data;
	} bwr_t;

endpackage

// File: hw/rtl/strassen_matrix_multiply.sv
// Loading takes one pair per cycle while the block is in its load state; no new pair is
// taken until the last element of C has been accepted. Each row of C is then fed in, one A
// element at a time, drains through the cell chain and is emitted column by column, each
// element held until the sink takes it.
// The chain length and the multiply/accumulate registers in each cell set the drain time.
// Reset (arst_n low, asynchronous) empties the block: load count zero, no result pending.
module strassen_matrix_multiply (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  smm_pkg::in_item_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output smm_pkg::out_item_t out_item
);

	// sequencer states
	typedef enum logic [3:0] {
		S_LOAD  = 4'b0001,
		S_FEED  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t state_q;

	// A is held row-major here and read one element per feed cycle;
	// B is spread by column over the cells.
	logic signed [smm_pkg::ElemW-1:0] a_store_q [smm_pkg::Cells];

	logic [smm_pkg::CntW-1:0] ld_cnt_q;
	logic [smm_pkg::IdxW-1:0] ld_row_q;
	logic [smm_pkg::IdxW-1:0] ld_col_q;
	logic [smm_pkg::IdxW-1:0] row_q;
	logic [smm_pkg::IdxW-1:0] t_q;
	logic [smm_pkg::IdxW-1:0] col_q;
	logic [smm_pkg::DrnW-1:0] drn_q;
	logic out_valid_q;
	smm_pkg::out_item_t out_q;

	// registered read of A, a register stage in front of the chain head
	logic feed_v_s1;
	logic feed_first_s1;
	logic [smm_pkg::IdxW-1:0] feed_t_s1;
	logic signed [smm_pkg::ElemW-1:0] a_rd_s1;

	logic in_acc;
	logic out_acc;
	logic ld_last;
	logic [smm_pkg::CntW-1:0] rd_addr;
	logic [smm_pkg::IdxW-1:0] sel_col;
	smm_pkg::out_item_t nxt_out;
	smm_pkg::feed_t feed0;
	smm_pkg::feed_t chain [smm_pkg::Size];
	smm_pkg::bwr_t bwr [smm_pkg::Size];
	logic signed [smm_pkg::CWidth-1:0] acc [smm_pkg::Size];

	assign in_ready = (state_q == S_LOAD);
	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid_q && out_ready;
	assign ld_last = (ld_row_q == smm_pkg::IdxW'(smm_pkg::Size - 1))
		&& (ld_col_q == smm_pkg::IdxW'(smm_pkg::Size - 1));

	// element A[row][t] into the head of the chain
	assign rd_addr = smm_pkg::CntW'(row_q * smm_pkg::Size) + smm_pkg::CntW'(t_q);
	assign feed0 = '{valid: feed_v_s1, first: feed_first_s1, a: a_rd_s1, t: feed_t_s1};

	genvar c;
	generate
		for (c = 0; c < smm_pkg::Size; c++) begin : g_cell
			assign bwr[c] = '{en: in_acc && (ld_col_q == smm_pkg::IdxW'(c)),
				row: ld_row_q, data: in_item.b_element[smm_pkg::ElemW-1:0]};
			if (c == 0) begin : g_head
				smm_cell u_cell (
					.clk(clk), .arst_n(arst_n), .feed_in(feed0), .feed_out(chain[c]),
					.bwr(bwr[c]), .acc(acc[c])
				);
			end else begin : g_body
				smm_cell u_cell (
					.clk(clk), .arst_n(arst_n), .feed_in(chain[c-1]), .feed_out(chain[c]),
					.bwr(bwr[c]), .acc(acc[c])
				);
			end
		end
	endgenerate

	// next result: column 0 when a row finishes draining, else the following column
	assign sel_col = (state_q == S_DRAIN) ? '0 : col_q + 1'b1;
	assign nxt_out = '{c_element: acc[sel_col],
		row_index: smm_pkg::OutIdxW'(row_q),
		col_index: smm_pkg::OutIdxW'(sel_col),
		last_flag: (row_q == smm_pkg::IdxW'(smm_pkg::Size - 1))
			&& (sel_col == smm_pkg::IdxW'(smm_pkg::Size - 1))};

	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_store_q[ld_cnt_q] <= in_item.a_element[smm_pkg::ElemW-1:0];
		end
		a_rd_s1 <= a_store_q[rd_addr];
		if ((state_q == S_DRAIN && drn_q == smm_pkg::DrnW'(smm_pkg::DrainCycles - 1))
			|| (out_acc && col_q != smm_pkg::IdxW'(smm_pkg::Size - 1))) begin
			out_q <= nxt_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			ld_cnt_q <= '0;
			ld_row_q <= '0;
			ld_col_q <= '0;
			row_q <= '0;
			t_q <= '0;
			col_q <= '0;
			drn_q <= '0;
			out_valid_q <= 1'b0;
			feed_v_s1 <= 1'b0;
			feed_first_s1 <= 1'b0;
			feed_t_s1 <= '0;
		end else begin
			feed_v_s1 <= (state_q == S_FEED);
			feed_first_s1 <= (t_q == '0);
			feed_t_s1 <= t_q;
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (ld_last) begin
							ld_cnt_q <= '0;
							ld_row_q <= '0;
							ld_col_q <= '0;
							row_q <= '0;
							t_q <= '0;
							state_q <= S_FEED;
						end else begin
							ld_cnt_q <= ld_cnt_q + 1'b1;
							if (ld_col_q == smm_pkg::IdxW'(smm_pkg::Size - 1)) begin
								ld_col_q <= '0;
								ld_row_q <= ld_row_q + 1'b1;
							end else begin
								ld_col_q <= ld_col_q + 1'b1;
							end
						end
					end
				end
				S_FEED: begin
					if (t_q == smm_pkg::IdxW'(smm_pkg::Size - 1)) begin
						t_q <= '0;
						drn_q <= '0;
						state_q <= S_DRAIN;
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				S_DRAIN: begin
					// wait for the tail cell to finish its sum
					if (drn_q == smm_pkg::DrnW'(smm_pkg::DrainCycles - 1)) begin
						col_q <= '0;
						out_valid_q <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						drn_q <= drn_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (out_acc) begin
						if (col_q == smm_pkg::IdxW'(smm_pkg::Size - 1)) begin
							out_valid_q <= 1'b0;
							if (row_q == smm_pkg::IdxW'(smm_pkg::Size - 1)) begin
								state_q <= S_LOAD;
							end else begin
								row_q <= row_q + 1'b1;
								state_q <= S_FEED;
							end
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

endmodule

// File: hw/rtl/smm_cell.sv
// One multiply-accumulate cell: holds one column of B, passes A on to the next cell.
module smm_cell (
	input  logic clk,
	input  logic arst_n,
	input  smm_pkg::feed_t feed_in,
	output smm_pkg::feed_t feed_out,
	input  smm_pkg::bwr_t bwr,
	output logic signed [smm_pkg::CWidth-1:0] acc
);

	logic signed [smm_pkg::ElemW-1:0] bcol_q [smm_pkg::Size];
	logic fv_q;
	logic ffirst_q;
	logic signed [smm_pkg::ElemW-1:0] fa_q;
	logic [smm_pkg::IdxW-1:0] ft_q;
	logic v_s1;
	logic first_s1;
	logic signed [2*smm_pkg::ElemW-1:0] prod_s1;
	logic signed [smm_pkg::CWidth-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (bwr.en) begin
			bcol_q[bwr.row] <= bwr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= 1'b0;
			v_s1 <= 1'b0;
		end else begin
			fv_q <= feed_in.valid;
			v_s1 <= fv_q;
		end
	end

	always_ff @(posedge clk) begin
		ffirst_q <= feed_in.first;
		fa_q <= feed_in.a;
		ft_q <= feed_in.t;
		first_s1 <= ffirst_q;
		prod_s1 <= fa_q * bcol_q[ft_q];
		if (v_s1) begin
			acc_q <= first_s1 ? smm_pkg::CWidth'(prod_s1)
				: acc_q + smm_pkg::CWidth'(prod_s1);
		end
	end

	assign feed_out = '{valid: fv_q, first: ffirst_q, a: fa_q, t: ft_q};
	assign acc = acc_q;

endmodule

// File: hw/rtl/smm_checker.sv
// Port-level checker for the matrix multiplier, bound to the top level.
`include "strassen_matrix_multiply_defines.svh"

module smm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input smm_pkg::in_item_t in_item,
	input logic out_valid,
	input logic out_ready,
	input smm_pkg::out_item_t out_item
);

	logic unused_in;
	assign unused_in = in_valid ^ (^in_item);

	`SMM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item), "stalled item changed")
	`SMM_ASSERT(a_one_side, clk, arst_n, !(in_ready && out_valid), "load and emit overlap")
	`SMM_ASSERT_NEXT(a_last_reload, clk, arst_n, out_valid && out_ready && out_item.last_flag, !out_valid && in_ready, "no reload after last item")
	`SMM_ASSERT(a_last_pos, clk, arst_n, !out_valid || (out_item.last_flag == ((out_item.row_index == smm_pkg::OutIdxW'(smm_pkg::Size - 1)) && (out_item.col_index == smm_pkg::OutIdxW'(smm_pkg::Size - 1)))), "last flag off position")

endmodule

bind strassen_matrix_multiply smm_checker u_smm_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_item(in_item), .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
);
